FILE: rtl/pqcg_pkg.sv
// Shared types and constants for the plane quad corner generator.
`default_nettype none

package pqcg_pkg;

    localparam int COORD_W = 32;
    localparam int N_W     = 18;
    localparam int DIM_W   = 31;

    // Axis scaling: reduce magnitudes below 2^NORM_SHIFT, then root and divide
    localparam int NORM_SHIFT = 20;
    localparam int ROUND_SHIFT = 10;
    localparam int RAD_W = 64;
    localparam int ROOT_W = 32;
    localparam int SQRT_STEPS = 32;
    localparam int DEN_W = ROOT_W + 1;
    localparam int QUO_W = 31;
    localparam int REM_W = 64;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic [2:0][COORD_W-1:0] vec3_t;

    typedef struct packed {
        vec3_t                   origin;
        logic [2:0][N_W-1:0]     normal;
        logic [DIM_W-1:0]        height;
    } xside_t;

    typedef struct packed {
        vec3_t origin;
        vec3_t xa;
        logic  xzero;
    } yside_t;

endpackage

`default_nettype wire

FILE: rtl/pqcg_scale.sv
// Pipelined axis scaler: direction of a vector scaled to half of a full extent.
`default_nettype none

module pqcg_scale #(
    parameter int CW = 19,
    parameter int SIDE_W = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [2:0][CW-1:0]           vec,
    input  wire logic [pqcg_pkg::DIM_W-1:0]   full,
    input  wire logic [SIDE_W-1:0]            side_in,
    output logic                              out_valid,
    output pqcg_pkg::vec3_t                   axis,
    output logic                              zero,
    output logic [SIDE_W-1:0]                 side_out
);
    import pqcg_pkg::*;

    localparam int SW   = (CW < NORM_SHIFT) ? CW : NORM_SHIFT;
    localparam int NG   = (CW + 7) / 8;
    localparam int PW   = NG * 8;
    localparam int BLW  = $clog2(PW + 1);
    localparam int KW   = $clog2(CW + 1);
    localparam int SQW  = 2 * SW;
    localparam int NUMW = SW + DIM_W;

    typedef struct packed {
        logic [2:0][NUMW-1:0] num;
        logic [2:0]           neg;
        logic                 zero;
        logic [SIDE_W-1:0]    side;
    } sq_carry_t;

    typedef struct packed {
        logic [DEN_W-1:0]  den;
        logic [2:0]        neg;
        logic              zero;
        logic [SIDE_W-1:0] side;
    } dv_carry_t;

    // Stage A: magnitudes
    logic                 a_valid_reg;
    logic [2:0][CW-1:0]   a_mag_reg;
    logic [2:0]           a_neg_reg;
    logic [DIM_W-1:0]     a_full_reg;
    logic [SIDE_W-1:0]    a_side_reg;
    // Stage B: largest magnitude
    logic                 b_valid_reg;
    logic [2:0][CW-1:0]   b_mag_reg;
    logic [2:0]           b_neg_reg;
    logic [CW-1:0]        b_max_reg;
    logic [DIM_W-1:0]     b_full_reg;
    logic [SIDE_W-1:0]    b_side_reg;
    // Stage C: leading one per byte group
    logic                 c_valid_reg;
    logic [2:0][CW-1:0]   c_mag_reg;
    logic [2:0]           c_neg_reg;
    logic [NG-1:0]        c_nz_reg;
    logic [NG-1:0][2:0]   c_hi_reg;
    logic                 c_zero_reg;
    logic [DIM_W-1:0]     c_full_reg;
    logic [SIDE_W-1:0]    c_side_reg;
    // Stage D: common shift
    logic                 d_valid_reg;
    logic [2:0][CW-1:0]   d_mag_reg;
    logic [2:0]           d_neg_reg;
    logic [KW-1:0]        d_k_reg;
    logic                 d_zero_reg;
    logic [DIM_W-1:0]     d_full_reg;
    logic [SIDE_W-1:0]    d_side_reg;
    // Stage E: reduced components
    logic                 e_valid_reg;
    logic [2:0][SW-1:0]   e_s_reg;
    logic [2:0]           e_neg_reg;
    logic                 e_zero_reg;
    logic [DIM_W-1:0]     e_full_reg;
    logic [SIDE_W-1:0]    e_side_reg;
    // Stage F: squares and numerators
    logic                 f_valid_reg;
    logic [2:0][SQW-1:0]  f_sq_reg;
    logic [2:0][NUMW-1:0] f_num_reg;
    logic [2:0]           f_neg_reg;
    logic                 f_zero_reg;
    logic [SIDE_W-1:0]    f_side_reg;

    // Root pipeline, index 0 holds the radicand
    logic                 sq_valid_reg [0:SQRT_STEPS];
    logic [RAD_W-1:0]     sq_v_reg     [0:SQRT_STEPS];
    logic [RAD_W-1:0]     sq_r_reg     [0:SQRT_STEPS];
    sq_carry_t            sq_car_reg   [0:SQRT_STEPS];

    // Divider pipeline, index 0 holds numerators and denominator
    logic                 dv_valid_reg [0:QUO_W];
    logic [REM_W-1:0]     dv_rem_reg   [0:QUO_W][0:2];
    logic [QUO_W-1:0]     dv_q_reg     [0:QUO_W][0:2];
    dv_carry_t            dv_car_reg   [0:QUO_W];

    logic                 o_valid_reg;
    vec3_t                o_axis_reg;
    logic                 o_zero_reg;
    logic [SIDE_W-1:0]    o_side_reg;

    logic [2:0][CW-1:0]   mag_next;
    logic [CW-1:0]        max_next;
    logic [PW-1:0]        mpad;
    logic [NG-1:0]        nz_next;
    logic [NG-1:0][2:0]   hi_next;
    logic [BLW-1:0]       blen;
    logic [KW-1:0]        k_next;
    logic [ROOT_W-1:0]    root;
    vec3_t                axis_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = vec[i][CW-1] ? (~vec[i] + 1'b1) : vec[i];
        end
        max_next = (a_mag_reg[0] > a_mag_reg[1]) ? a_mag_reg[0] : a_mag_reg[1];
        if (a_mag_reg[2] > max_next)
        begin
            max_next = a_mag_reg[2];
        end
    end

    always_comb
    begin
        mpad = PW'(b_max_reg);
        for (int g = 0; g < NG; g++)
        begin
            nz_next[g] = |mpad[g*8 +: 8];
            hi_next[g] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (mpad[g*8 + b])
                begin
                    hi_next[g] = 3'(b);
                end
            end
        end
    end

    always_comb
    begin
        blen = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (c_nz_reg[g])
            begin
                blen = BLW'(g * 8) + BLW'(c_hi_reg[g]) + BLW'(1);
            end
        end
        k_next = (blen > BLW'(NORM_SHIFT)) ? KW'(blen - BLW'(NORM_SHIFT)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            sq_valid_reg[0] <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_neg_reg[i] <= vec[i][CW-1];
            end
            a_mag_reg  <= mag_next;
            a_full_reg <= full;
            a_side_reg <= side_in;

            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
            b_max_reg  <= max_next;
            b_full_reg <= a_full_reg;
            b_side_reg <= a_side_reg;

            c_mag_reg  <= b_mag_reg;
            c_neg_reg  <= b_neg_reg;
            c_nz_reg   <= nz_next;
            c_hi_reg   <= hi_next;
            c_zero_reg <= (b_max_reg == '0);
            c_full_reg <= b_full_reg;
            c_side_reg <= b_side_reg;

            d_mag_reg  <= c_mag_reg;
            d_neg_reg  <= c_neg_reg;
            d_k_reg    <= k_next;
            d_zero_reg <= c_zero_reg;
            d_full_reg <= c_full_reg;
            d_side_reg <= c_side_reg;

            for (int i = 0; i < 3; i++)
            begin
                e_s_reg[i] <= SW'(d_mag_reg[i] >> d_k_reg);
            end
            e_neg_reg  <= d_neg_reg;
            e_zero_reg <= d_zero_reg;
            e_full_reg <= d_full_reg;
            e_side_reg <= d_side_reg;

            for (int i = 0; i < 3; i++)
            begin
                f_sq_reg[i]  <= e_s_reg[i] * e_s_reg[i];
                f_num_reg[i] <= NUMW'(e_s_reg[i]) * NUMW'(e_full_reg);
            end
            f_neg_reg  <= e_neg_reg;
            f_zero_reg <= e_zero_reg;
            f_side_reg <= e_side_reg;

            sq_v_reg[0] <= (RAD_W'(f_sq_reg[0]) + RAD_W'(f_sq_reg[1])
                            + RAD_W'(f_sq_reg[2])) << NORM_SHIFT;
            sq_r_reg[0] <= '0;
            sq_car_reg[0] <= '{num: f_num_reg, neg: f_neg_reg, zero: f_zero_reg,
                               side: f_side_reg};
        end
    end

    // One result bit per stage, trial bit walks down by two places
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam logic [RAD_W-1:0] TBIT = RAD_W'(1) << (RAD_W - 2 - 2 * j);
        logic [RAD_W-1:0] trial;

        assign trial = sq_r_reg[j] + TBIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[j+1] <= sq_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sq_v_reg[j] >= trial)
                begin
                    sq_v_reg[j+1] <= sq_v_reg[j] - trial;
                    sq_r_reg[j+1] <= (sq_r_reg[j] >> 1) + TBIT;
                end
                else
                begin
                    sq_v_reg[j+1] <= sq_v_reg[j];
                    sq_r_reg[j+1] <= sq_r_reg[j] >> 1;
                end
                sq_car_reg[j+1] <= sq_car_reg[j];
            end
        end
    end

    assign root = sq_r_reg[SQRT_STEPS][ROOT_W-1:0];

    // Rounded quotient: (num * 2^10 + len) / (2 * len)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= sq_valid_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= (REM_W'(sq_car_reg[SQRT_STEPS].num[i]) << ROUND_SHIFT)
                                    + REM_W'(root);
                dv_q_reg[0][i]   <= '0;
            end
            dv_car_reg[0] <= '{den: {root, 1'b0}, neg: sq_car_reg[SQRT_STEPS].neg,
                               zero: sq_car_reg[SQRT_STEPS].zero,
                               side: sq_car_reg[SQRT_STEPS].side};
        end
    end

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        localparam int SH = QUO_W - 1 - j;
        logic [REM_W-1:0] dsh;

        assign dsh = REM_W'(dv_car_reg[j].den) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_rem_reg[j][i] >= dsh)
                    begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i] - dsh;
                        dv_q_reg[j+1][i]   <= {dv_q_reg[j][i][QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i];
                        dv_q_reg[j+1][i]   <= {dv_q_reg[j][i][QUO_W-2:0], 1'b0};
                    end
                end
                dv_car_reg[j+1] <= dv_car_reg[j];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_car_reg[QUO_W].zero)
            begin
                axis_next[i] = '0;
            end
            else if (dv_car_reg[QUO_W].neg[i])
            begin
                axis_next[i] = ~COORD_W'(dv_q_reg[QUO_W][i]) + 1'b1;
            end
            else
            begin
                axis_next[i] = COORD_W'(dv_q_reg[QUO_W][i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= dv_valid_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_axis_reg <= axis_next;
            o_zero_reg <= dv_car_reg[QUO_W].zero;
            o_side_reg <= dv_car_reg[QUO_W].side;
        end
    end

    assign out_valid = o_valid_reg;
    assign axis      = o_axis_reg;
    assign zero      = o_zero_reg;
    assign side_out  = o_side_reg;

endmodule

`default_nettype wire

FILE: rtl/plane_quad_corner_generator.sv
// Plane quad corner generator: four rectangle corners from origin, normal and extents.
// Usage:
//   Item channel (item_valid / item_stall) takes one plane per transaction: origin,
//   normal, full width and full height, all in fixed point with FRAC_BITS fraction
//   bits. Corner channel (corner_valid / corner_stall) returns four transactions per
//   plane in fan order: top-left, top-right, bottom-right, bottom-left; last marks
//   the fourth, degenerate is set on all four when an axis direction was the zero vector.
//   Path: a plane runs through a 148-stage pipeline (input and helper stages, two
//   axis scalers, each a 32-step root and a 31-step divider, plus cross product)
//   into one item register and the corner output register; after the first
//   corner the other three follow one per cycle while corner_stall is low.
//   Throughput: a plane may enter every cycle while the pipeline has room; the
//   corner port emits one corner per cycle while corner_stall is low, so the
//   sustained plane rate is set by the corner output port.
//   Stall: when corner_stall is high the output holds; while the item register
//   and pipeline tail are both occupied and the fourth corner is not being loaded,
//   the whole pipeline freezes and item_stall rises. Nothing is dropped or repeated.
//   Reset: rst_n clears all valid bits; the block comes up empty and ready.
`default_nettype none

module plane_quad_corner_generator #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic signed [31:0]  origin_x,
    input  wire logic signed [31:0]  origin_y,
    input  wire logic signed [31:0]  origin_z,
    input  wire logic signed [17:0]  normal_x,
    input  wire logic signed [17:0]  normal_y,
    input  wire logic signed [17:0]  normal_z,
    input  wire logic [30:0]         plane_width,
    input  wire logic [30:0]         plane_height,
    output logic                     corner_valid,
    input  wire logic                corner_stall,
    output logic signed [31:0]       corner_x,
    output logic signed [31:0]       corner_y,
    output logic signed [31:0]       corner_z,
    output logic [1:0]               corner_index,
    output logic                     last,
    output logic                     degenerate
);
    import pqcg_pkg::*;

    localparam longint ONE_RAW = 64'd1 << FRAC_BITS;
    localparam longint EPS_RAW = ONE_RAW / 10000;
    localparam int HW   = ((FRAC_BITS > N_W) ? FRAC_BITS : N_W) + 2;
    localparam int UW   = N_W + 1;
    localparam int PRW  = N_W + COORD_W;
    localparam int VW   = PRW + 1;
    localparam int SUMW = COORD_W + 2;
    localparam int XSW  = $bits(xside_t);
    localparam int YSW  = $bits(yside_t);

    logic adv;
    logic ser_take;
    logic out_load;

    // Input register
    logic                t0_valid_reg;
    vec3_t               t0_origin_reg;
    logic [2:0][N_W-1:0] t0_normal_reg;
    logic [DIM_W-1:0]    t0_width_reg;
    logic [DIM_W-1:0]    t0_height_reg;

    // Helper vector stage
    logic                t1_valid_reg;
    logic [2:0][UW-1:0]  t1_u_reg;
    logic [DIM_W-1:0]    t1_width_reg;
    xside_t              t1_side_reg;

    logic [N_W-1:0]      ay;
    logic [HW-1:0]       dy;
    logic [HW-1:0]       adiff;
    logic                near_pole;
    logic [UW-1:0]       nx_e;
    logic [UW-1:0]       ny_e;
    logic [UW-1:0]       nz_e;
    logic [UW-1:0]       nx_neg;
    logic [2:0][UW-1:0]  u_next;

    logic                x_valid;
    vec3_t               xa;
    logic                xzero;
    logic [XSW-1:0]      x_side_bits;
    xside_t              x_side;

    // Cross product stages
    logic                c1_valid_reg;
    logic signed [PRW-1:0] c1_p_reg [0:5];
    yside_t              c1_side_reg;
    logic [DIM_W-1:0]    c1_height_reg;
    logic                c2_valid_reg;
    logic [2:0][VW-1:0]  c2_v_reg;
    yside_t              c2_side_reg;
    logic [DIM_W-1:0]    c2_height_reg;

    logic                y_valid;
    vec3_t               ya;
    logic                yzero;
    logic [YSW-1:0]      y_side_bits;
    yside_t              y_side;

    // Corner serializer
    logic                hold_valid_reg;
    vec3_t               hold_origin_reg;
    vec3_t               hold_xa_reg;
    vec3_t               hold_ya_reg;
    logic                hold_deg_reg;
    logic [1:0]          cnt_reg;
    logic                corner_valid_reg;
    vec3_t               corner_reg;
    logic [1:0]          corner_index_reg;
    logic                last_reg;
    logic                deg_reg;

    logic                x_neg;
    logic                y_neg;
    logic [SUMW-1:0]     sum;
    vec3_t               corner_next;

    assign out_load   = !corner_valid_reg || !corner_stall;
    assign ser_take   = !hold_valid_reg || (out_load && cnt_reg == CORNER_BL);
    assign adv        = !y_valid || ser_take;
    assign item_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_valid_reg <= 1'b0;
            t1_valid_reg <= 1'b0;
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t0_valid_reg <= item_valid;
            t1_valid_reg <= t0_valid_reg;
            c1_valid_reg <= x_valid;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    // Alternate helper when |ny| lies within the tolerance of one
    always_comb
    begin
        ay        = t0_normal_reg[1][N_W-1] ? (~t0_normal_reg[1] + 1'b1) : t0_normal_reg[1];
        dy        = HW'(ay) - HW'(ONE_RAW);
        adiff     = dy[HW-1] ? (~dy + 1'b1) : dy;
        near_pole = adiff < HW'(EPS_RAW);
        nx_e      = {t0_normal_reg[0][N_W-1], t0_normal_reg[0]};
        ny_e      = {t0_normal_reg[1][N_W-1], t0_normal_reg[1]};
        nz_e      = {t0_normal_reg[2][N_W-1], t0_normal_reg[2]};
        nx_neg    = ~nx_e + 1'b1;
        u_next[0] = near_pole ? ny_e : nz_e;
        u_next[1] = near_pole ? nx_neg : '0;
        u_next[2] = near_pole ? '0 : nx_neg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_origin_reg    <= {origin_z, origin_y, origin_x};
            t0_normal_reg    <= {normal_z, normal_y, normal_x};
            t0_width_reg     <= plane_width;
            t0_height_reg    <= plane_height;

            t1_u_reg         <= u_next;
            t1_width_reg     <= t0_width_reg;
            t1_side_reg      <= '{origin: t0_origin_reg, normal: t0_normal_reg,
                                  height: t0_height_reg};
        end
    end

    pqcg_scale #(
        .CW     (UW),
        .SIDE_W (XSW)
    ) u_xscale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (t1_valid_reg),
        .vec       (t1_u_reg),
        .full      (t1_width_reg),
        .side_in   (t1_side_reg),
        .out_valid (x_valid),
        .axis      (xa),
        .zero      (xzero),
        .side_out  (x_side_bits)
    );

    assign x_side = x_side_bits;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_p_reg[0] <= $signed(x_side.normal[1]) * $signed(xa[2]);
            c1_p_reg[1] <= $signed(x_side.normal[2]) * $signed(xa[1]);
            c1_p_reg[2] <= $signed(x_side.normal[2]) * $signed(xa[0]);
            c1_p_reg[3] <= $signed(x_side.normal[0]) * $signed(xa[2]);
            c1_p_reg[4] <= $signed(x_side.normal[0]) * $signed(xa[1]);
            c1_p_reg[5] <= $signed(x_side.normal[1]) * $signed(xa[0]);
            c1_side_reg   <= '{origin: x_side.origin, xa: xa, xzero: xzero};
            c1_height_reg <= x_side.height;

            c2_v_reg[0] <= VW'(c1_p_reg[0]) - VW'(c1_p_reg[1]);
            c2_v_reg[1] <= VW'(c1_p_reg[2]) - VW'(c1_p_reg[3]);
            c2_v_reg[2] <= VW'(c1_p_reg[4]) - VW'(c1_p_reg[5]);
            c2_side_reg   <= c1_side_reg;
            c2_height_reg <= c1_height_reg;
        end
    end

    pqcg_scale #(
        .CW     (VW),
        .SIDE_W (YSW)
    ) u_yscale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c2_valid_reg),
        .vec       (c2_v_reg),
        .full      (c2_height_reg),
        .side_in   (c2_side_reg),
        .out_valid (y_valid),
        .axis      (ya),
        .zero      (yzero),
        .side_out  (y_side_bits)
    );

    assign y_side = y_side_bits;

    // Corner sums origin +- x +- y, saturated once
    always_comb
    begin
        x_neg = (cnt_reg == CORNER_TL) || (cnt_reg == CORNER_BL);
        y_neg = (cnt_reg == CORNER_BR) || (cnt_reg == CORNER_BL);
        sum   = '0;
        for (int i = 0; i < 3; i++)
        begin
            sum = SUMW'($signed(hold_origin_reg[i]))
                + (x_neg ? -SUMW'($signed(hold_xa_reg[i])) : SUMW'($signed(hold_xa_reg[i])))
                + (y_neg ? -SUMW'($signed(hold_ya_reg[i])) : SUMW'($signed(hold_ya_reg[i])));
            if (sum[SUMW-1:COORD_W-1] == '0 || sum[SUMW-1:COORD_W-1] == '1)
            begin
                corner_next[i] = sum[COORD_W-1:0];
            end
            else
            begin
                corner_next[i] = sum[SUMW-1] ? COORD_MIN : COORD_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            cnt_reg          <= CORNER_TL;
            corner_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                corner_valid_reg <= hold_valid_reg;
                if (hold_valid_reg)
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                end
            end
            if (ser_take)
            begin
                hold_valid_reg <= y_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && hold_valid_reg)
        begin
            corner_reg       <= corner_next;
            corner_index_reg <= cnt_reg;
            last_reg         <= (cnt_reg == CORNER_BL);
            deg_reg          <= hold_deg_reg;
        end
        if (ser_take && y_valid)
        begin
            hold_origin_reg <= y_side.origin;
            hold_xa_reg     <= y_side.xa;
            hold_ya_reg     <= ya;
            hold_deg_reg    <= y_side.xzero || yzero;
        end
    end

    assign corner_valid = corner_valid_reg;
    assign corner_x     = corner_reg[0];
    assign corner_y     = corner_reg[1];
    assign corner_z     = corner_reg[2];
    assign corner_index = corner_index_reg;
    assign last         = last_reg;
    assign degenerate   = deg_reg;

    a_last_on_fourth: assert property (@(posedge clk) disable iff (!rst_n)
        corner_valid |-> (last == (corner_index == CORNER_BL)))
        else $error("last flag does not match corner index");

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        corner_valid && !corner_stall && !last
        |=> corner_valid && corner_index == $past(corner_index) + 2'd1)
        else $error("corners of one transaction not back to back in fan order");

    a_deg_constant: assert property (@(posedge clk) disable iff (!rst_n)
        corner_valid && !corner_stall && !last |=> degenerate == $past(degenerate))
        else $error("degenerate flag changed within one plane");

    a_tail_held: assert property (@(posedge clk) disable iff (!rst_n)
        y_valid && !adv |=> y_valid)
        else $error("pipeline tail lost while frozen");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> y_valid && hold_valid_reg)
        else $error("input stalled without a full tail");

endmodule

`default_nettype wire

FILE: tb/sv/plane_quad_corner_generator_test.sv
// Self-checking testbench for the plane quad corner generator.
`timescale 1ns / 1ps
`default_nettype none

module plane_quad_corner_generator_test;
    import pqcg_pkg::*;

    localparam int FRAC = 16;
    localparam longint ONE = longint'(1) << FRAC;
    localparam longint EPS = (ONE * 1) / 10000;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         index;
        logic               fourth;
        logic               zero_axis;
    } corner_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [17:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic [30:0] plane_width = '0, plane_height = '0;
    logic corner_valid;
    logic corner_stall = 1'b0;
    logic signed [31:0] corner_x, corner_y, corner_z;
    logic [1:0] corner_index;
    logic last, degenerate;

    corner_t expected_corners[$];
    int error_count = 0;
    int idle_count = 0;
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_off = 1'b0;

    plane_quad_corner_generator #(.FRAC_BITS(FRAC)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .plane_width(plane_width), .plane_height(plane_height),
        .corner_valid(corner_valid), .corner_stall(corner_stall),
        .corner_x(corner_x), .corner_y(corner_y), .corner_z(corner_z),
        .corner_index(corner_index), .last(last), .degenerate(degenerate)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Scale c to length full/2; return 1 when c is zero.
    function automatic bit scale_to_half(input longint c[3], input longint unsigned full,
                                         output longint res[3]);
        longint unsigned mag[3], m, s, sum, len, den, num, q;
        int sh;
        m = 0;
        sum = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            res = '{0, 0, 0};
            return 1'b1;
        end
        while ((m >> sh) >= (longint'(1) << NORM_SHIFT)) sh++;
        for (int i = 0; i < 3; i++) begin
            s = mag[i] >> sh;
            sum += s * s;
        end
        len = int_sqrt(sum << 20);
        den = 2 * len;
        for (int i = 0; i < 3; i++) begin
            s = mag[i] >> sh;
            num = (s * full) << 10;
            q = (2 * num + den) / (2 * den);
            res[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b0;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return COORD_MAX;
        if (v < -64'sd2147483648) return COORD_MIN;
        return v[31:0];
    endfunction

    task automatic predict_corners(logic signed [31:0] ox, oy, oz,
                                   logic signed [17:0] nx, ny, nz, logic [30:0] w, h);
        longint o[3], n[3], helper_cross[3], xa[3], v[3], ya[3], ay, diff;
        bit zero_axis;
        int sx[4], sy[4];
        corner_t c;
        sx = '{-1, 1, 1, -1};
        sy = '{1, 1, -1, -1};
        o = '{ox, oy, oz};
        n = '{nx, ny, nz};
        ay = n[1] < 0 ? -n[1] : n[1];
        diff = ay - ONE;
        if (diff < 0) diff = -diff;
        if (diff < EPS) helper_cross = '{n[1], -n[0], 0};
        else helper_cross = '{n[2], 0, -n[0]};
        zero_axis = scale_to_half(helper_cross, w, xa);
        v[0] = n[1] * xa[2] - n[2] * xa[1];
        v[1] = n[2] * xa[0] - n[0] * xa[2];
        v[2] = n[0] * xa[1] - n[1] * xa[0];
        if (scale_to_half(v, h, ya)) zero_axis = 1'b1;
        for (int k = 0; k < 4; k++) begin
            c.x = clamp32(o[0] + sx[k] * xa[0] + sy[k] * ya[0]);
            c.y = clamp32(o[1] + sx[k] * xa[1] + sy[k] * ya[1]);
            c.z = clamp32(o[2] + sx[k] * xa[2] + sy[k] * ya[2]);
            c.index = k[1:0];
            c.fourth = (k[1:0] == CORNER_BL);
            c.zero_axis = zero_axis;
            expected_corners.push_back(c);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Send one plane and wait until it is taken; valid stays up for the next one.
    task automatic send_plane(logic signed [31:0] ox, oy, oz,
                              logic signed [17:0] nx, ny, nz, logic [30:0] w, h);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item_valid <= 1'b1;
        origin_x <= ox; origin_y <= oy; origin_z <= oz;
        normal_x <= nx; normal_y <= ny; normal_z <= nz;
        plane_width <= w; plane_height <= h;
        do @(posedge clk); while (item_stall);
        predict_corners(ox, oy, oz, nx, ny, nz, w, h);
    endtask

    function automatic logic signed [17:0] rand_normal();
        int r;
        r = $urandom_range(0, 131072);
        return 18'(r - 65536);
    endfunction

    task automatic send_random_plane();
        logic signed [17:0] nx, ny, nz;
        logic [30:0] w, h;
        nx = rand_normal(); ny = rand_normal(); nz = rand_normal();
        case ($urandom_range(0, 5))
            0: begin ny = 18'(($urandom_range(0, 1) ? 1 : -1)
                             * (65536 + $urandom_range(0, 14) - 7));
                nx = 18'($urandom_range(0, 64) - 32); nz = 18'($urandom_range(0, 64) - 32); end
            1: begin nx = '0; nz = '0; end
            2: nx = 18'($urandom_range(0, 262143));
            default: ;
        endcase
        w = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
        h = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
        if ($urandom_range(0, 15) == 0) w = '0;
        if ($urandom_range(0, 15) == 0) h = '0;
        send_plane($urandom, $urandom, $urandom, nx, ny, nz, w, h);
    endtask

    task automatic test_extremes();
        send_plane(0, 0, 0, 0, 65536, 0, 65536 * 2, 65536 * 4);
        send_plane(0, 0, 0, 0, -65536, 0, 65536, 65536);
        send_plane(0, 0, 0, 65536, 0, 0, 65536, 65536);
        send_plane(0, 0, 0, 0, 0, -65536, 31'h7fffffff, 31'h7fffffff);
        send_plane(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 65536,
                   31'h7fffffff, 31'h7fffffff);
        send_plane(32'sh80000000, 32'sh80000000, 32'sh80000000, -65536, 0, 0,
                   31'h7fffffff, 31'h7fffffff);
        send_plane(100, -100, 5, 46341, 0, 46341, 0, 65536);
        send_plane(100, -100, 5, 46341, 0, 46341, 65536, 0);
        send_plane(0, 0, 0, 0, 0, 0, 65536, 65536);
        send_plane(0, 0, 0, 0, 65536 - 6, 0, 65536, 65536);
        send_plane(0, 0, 0, 0, 65536 + 6, 0, 65536, 65536);
        send_plane(0, 0, 0, 0, -65536 + 7, 0, 65536, 65536);
        send_plane(0, 0, 0, 10, 65536 - 7, 3, 65536, 65536);
        send_plane(0, 0, 0, 0, 65536, 0, 65536, 65536);
        send_plane(0, 0, 0, 300, 200, 100, 655360, 327680);
        send_plane(0, 0, 0, 18'sh1ffff, 18'sh1ffff, 18'sh1ffff, 1, 1);
        send_plane(-1, -1, -1, 18'sh20000, 18'sh20000, 18'sh20000, 31'h7fffffff, 3);
    endtask

    task automatic test_random_planes();
        repeat (95) send_random_plane();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        repeat (60) send_random_plane();
        hold_off = 1'b0;
    endtask

    task automatic test_full_rate();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        repeat (30) send_random_plane();
    endtask

    // Receiver stall bursts, plus one long hold-off.
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                corner_stall <= 1'b1;
                repeat (400) @(posedge clk);
                corner_stall <= 1'b0;
                wait (!hold_off);
            end
            else if (receiver_idles && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 18);
                corner_stall <= 1'b1;
                repeat (n) @(posedge clk);
                corner_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        corner_t want;
        if (rst_n && corner_valid && !corner_stall) begin
            if (expected_corners.size() == 0) begin
                $display("unexpected corner at %0t", $realtime);
                error_count++;
            end
            else begin
                want = expected_corners.pop_front();
                if (corner_x !== want.x) report_mismatch("corner_x", corner_x, want.x);
                if (corner_y !== want.y) report_mismatch("corner_y", corner_y, want.y);
                if (corner_z !== want.z) report_mismatch("corner_z", corner_z, want.z);
                if (corner_index !== want.index)
                    report_mismatch("corner_index", corner_index, want.index);
                if (last !== want.fourth) report_mismatch("last", last, want.fourth);
                if (degenerate !== want.zero_axis)
                    report_mismatch("degenerate", degenerate, want.zero_axis);
            end
        end
    end

    // Count cycles without any transaction.
    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (corner_valid && !corner_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_random_planes();
        test_backpressure();
        test_full_rate();
        item_valid <= 1'b0;
        wait (expected_corners.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_corners.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
